FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

FILE: rtl/core/astt_pkg.sv
// ----------------------------------------------------------------------------
// astt_pkg
// Shared constants, codes and structures of the signalling transaction tracker.
// ----------------------------------------------------------------------------
package astt_pkg;

  // Width of the generation counter; 1 to 32.
  localparam int unsigned GENERATION_BITS = 16;
  localparam int unsigned TICKET_W        = 16;
  // Ticket compare width: the wider of the counter and the ticket field.
  localparam int unsigned CMP_W = (GENERATION_BITS > TICKET_W) ? GENERATION_BITS : TICKET_W;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] MIN_LEN       = 8'd2;
  localparam logic [1:0] FRAME_LEN     = 2'd2;
  localparam logic [1:0] PAYLOAD_OFS   = 2'd2;
  localparam logic [1:0] PKT_SINGLE    = 2'd0;
  localparam logic [1:0] MSG_COMMAND   = 2'd0;
  localparam logic [1:0] MSG_GEN_REJ   = 2'd1;
  localparam logic [1:0] MSG_ACCEPT    = 2'd2;
  localparam logic [1:0] MSG_REJECT    = 2'd3;

  typedef enum logic [1:0] {
    KIND_BEGIN    = 2'd0,
    KIND_RESPONSE = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_INVALID    = 4'd1,
    ST_FAULTED    = 4'd2,
    ST_BUSY       = 4'd3,
    ST_STALE      = 4'd4,
    ST_UNEXPECTED = 4'd5,
    ST_TRUNCATED  = 4'd6,
    ST_FRAGMENT   = 4'd7,
    ST_REJECTED   = 4'd8
  } status_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_t                 kind;
    logic                  args_bad;    // begin: signal id or buffer room out of range
    logic [5:0]            sig;         // begin: requested id, response: received id
    logic [TICKET_W-1:0]   ticket;
    logic                  short_len;   // response shorter than its header
    logic [3:0]            label;
    logic                  pkt_single;
    logic [1:0]            mtype;
  } cmd_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [7:0]          header_out;
    logic [5:0]          signal_out;
    logic [1:0]          frame_length;
    logic [TICKET_W-1:0] ticket_out;
    logic [1:0]          data_offset;
  } res_t;

endpackage

FILE: rtl/core/astt_in_if.sv
// ----------------------------------------------------------------------------
// astt_in_if
// Request channel: one beat carries one begin, response check or reset item.
// ----------------------------------------------------------------------------
interface astt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] req_signal;
  logic [7:0] buffer_room;
  logic [15:0] ticket;
  logic [7:0] response_length;
  logic [7:0] header_byte;
  logic [7:0] signal_byte;

  modport source (
    output valid, kind, req_signal, buffer_room, ticket, response_length,
           header_byte, signal_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, req_signal, buffer_room, ticket, response_length,
           header_byte, signal_byte,
    output ready
  );
endinterface

FILE: rtl/core/astt_out_if.sv
// ----------------------------------------------------------------------------
// astt_out_if
// Result channel: one beat carries the outcome of one request.
// ----------------------------------------------------------------------------
interface astt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  header_out;
  logic [5:0]  signal_out;
  logic [1:0]  frame_length;
  logic [15:0] ticket_out;
  logic [1:0]  data_offset;

  modport source (
    output valid, status, header_out, signal_out, frame_length, ticket_out,
           data_offset,
    input  ready
  );
  modport sink (
    input  valid, status, header_out, signal_out, frame_length, ticket_out,
           data_offset,
    output ready
  );
endinterface

FILE: rtl/core/astt_front.sv
// ----------------------------------------------------------------------------
// astt_front
// Accepts request beats and reduces them to the flags the back end needs.
// ----------------------------------------------------------------------------
module astt_front (
  astt_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output astt_pkg::cmd_t  push_cmd
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_cmd            = '0;
    push_cmd.kind       = astt_pkg::kind_t'(in_ch.kind);
    // A usable signal id lies between 1 and 63.
    push_cmd.args_bad   = (in_ch.req_signal[7:6] != 2'b00) ||
                          (in_ch.req_signal[5:0] == 6'd0) ||
                          (in_ch.buffer_room < astt_pkg::MIN_LEN);
    push_cmd.sig        = (push_cmd.kind == astt_pkg::KIND_BEGIN) ?
                          in_ch.req_signal[5:0] : in_ch.signal_byte[5:0];
    push_cmd.ticket     = in_ch.ticket;
    push_cmd.short_len  = (in_ch.response_length < astt_pkg::MIN_LEN);
    push_cmd.label      = in_ch.header_byte[7:4];
    push_cmd.pkt_single = (in_ch.header_byte[3:2] == astt_pkg::PKT_SINGLE);
    push_cmd.mtype      = in_ch.header_byte[1:0];
  end

endmodule

FILE: rtl/core/astt_queue.sv
// ----------------------------------------------------------------------------
// astt_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module astt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  astt_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output astt_pkg::cmd_t  pop_cmd
);

  localparam int unsigned DEPTH = astt_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = astt_pkg::QPTR_W;
  localparam int unsigned CW    = astt_pkg::QCNT_W;

  astt_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/astt_back.sv
// ----------------------------------------------------------------------------
// astt_back
// Holds the transaction state, resolves each queued item and registers its
// result for the output channel.
// ----------------------------------------------------------------------------
module astt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  astt_pkg::cmd_t  pop_cmd,
  astt_out_if.source      out_ch
);

  localparam int unsigned GW = astt_pkg::GENERATION_BITS;
  localparam int unsigned CW = astt_pkg::CMP_W;
  localparam int unsigned TW = astt_pkg::TICKET_W;

  logic [GW-1:0] gen_r, gen_nxt;
  logic [3:0]    next_label_r, next_label_nxt;
  logic [3:0]    pend_label_r, pend_label_nxt;
  logic [5:0]    pend_sig_r, pend_sig_nxt;
  logic          pend_r, pend_nxt;
  logic          fault_r, fault_nxt;
  logic          out_valid_r, out_valid_nxt;
  astt_pkg::res_t res_r, res_nxt;
  logic          do_pop;
  logic          tick_match;

  assign pop_ready  = !out_valid_r || out_ch.ready;
  assign do_pop     = pop_valid && pop_ready;
  assign tick_match = (CW'(gen_r) == CW'(pop_cmd.ticket));

  always_comb begin
    gen_nxt        = gen_r;
    next_label_nxt = next_label_r;
    pend_label_nxt = pend_label_r;
    pend_sig_nxt   = pend_sig_r;
    pend_nxt       = pend_r;
    fault_nxt      = fault_r;
    res_nxt        = '0;
    res_nxt.status = astt_pkg::ST_OK;

    case (pop_cmd.kind)
      astt_pkg::KIND_BEGIN: begin
        if (pop_cmd.args_bad) begin
          res_nxt.status = astt_pkg::ST_INVALID;
        end else if (fault_r) begin
          res_nxt.status = astt_pkg::ST_FAULTED;
        end else if (pend_r) begin
          res_nxt.status = astt_pkg::ST_BUSY;
        end else begin
          next_label_nxt       = next_label_r + 4'd1;
          pend_label_nxt       = next_label_r;
          pend_sig_nxt         = pop_cmd.sig;
          pend_nxt             = 1'b1;
          res_nxt.header_out   = {next_label_r, 4'b0000};
          res_nxt.signal_out   = pop_cmd.sig;
          res_nxt.frame_length = astt_pkg::FRAME_LEN;
          res_nxt.ticket_out   = TW'(gen_r);
        end
      end
      astt_pkg::KIND_RESPONSE: begin
        if (!tick_match) begin
          res_nxt.status = astt_pkg::ST_STALE;
        end else if (fault_r) begin
          res_nxt.status = astt_pkg::ST_FAULTED;
        end else if (!pend_r) begin
          res_nxt.status = astt_pkg::ST_UNEXPECTED;
        end else if (pop_cmd.short_len) begin
          pend_nxt       = 1'b0;
          fault_nxt      = 1'b1;
          res_nxt.status = astt_pkg::ST_TRUNCATED;
        end else if ((pop_cmd.label != pend_label_r) || (pop_cmd.sig != pend_sig_r)) begin
          res_nxt.status = astt_pkg::ST_UNEXPECTED;
        end else begin
          pend_nxt = 1'b0;
          if (!pop_cmd.pkt_single) begin
            fault_nxt      = 1'b1;
            res_nxt.status = astt_pkg::ST_FRAGMENT;
          end else if ((pop_cmd.mtype == astt_pkg::MSG_REJECT) ||
                       (pop_cmd.mtype == astt_pkg::MSG_GEN_REJ)) begin
            res_nxt.status = astt_pkg::ST_REJECTED;
          end else if (pop_cmd.mtype == astt_pkg::MSG_COMMAND) begin
            fault_nxt      = 1'b1;
            res_nxt.status = astt_pkg::ST_UNEXPECTED;
          end else begin
            res_nxt.data_offset = astt_pkg::PAYLOAD_OFS;
          end
        end
      end
      astt_pkg::KIND_CLEAR: begin
        gen_nxt        = gen_r + GW'(1);
        pend_label_nxt = '0;
        pend_sig_nxt   = '0;
        pend_nxt       = 1'b0;
        fault_nxt      = 1'b0;
      end
      default: begin
        res_nxt.status = astt_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r        <= '0;
      next_label_r <= '0;
      pend_label_r <= '0;
      pend_sig_r   <= '0;
      pend_r       <= 1'b0;
      fault_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (do_pop) begin
        gen_r        <= gen_nxt;
        next_label_r <= next_label_nxt;
        pend_label_r <= pend_label_nxt;
        pend_sig_r   <= pend_sig_nxt;
        pend_r       <= pend_nxt;
        fault_r      <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.header_out   = res_r.header_out;
  assign out_ch.signal_out   = res_r.signal_out;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.ticket_out   = res_r.ticket_out;
  assign out_ch.data_offset  = res_r.data_offset;

endmodule

FILE: rtl/core/avdtp_signal_transaction_tracker_unit.sv
// The tracker keeps one outstanding signalling command at a time. Each request
// beat (begin a command, check a response, or reset the transaction) produces
// exactly one result beat, in order. The block sustains one request per clock
// cycle while its queue has room. A request that is taken is written into the
// queue, then carried through the state update into the output register, from
// which its result is offered; it is held back only while the output is
// stalled. The back end reads and updates the tracker state once per cycle
// while its output register is empty or being emptied.
// ----------------------------------------------------------------------------
// avdtp_signal_transaction_tracker_unit
// Top level: front end, two-entry queue and back end of the tracker.
// ----------------------------------------------------------------------------
module avdtp_signal_transaction_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  astt_in_if.sink     in_ch,
  astt_out_if.source  out_ch
);

  // The front end only classifies, so it never holds a beat of its own; the
  // input is stalled only when the queue is full, which needs the output side
  // to have refused results for a while.
  logic            push_valid, push_ready;
  astt_pkg::cmd_t  push_cmd;
  logic            pop_valid, pop_ready;
  astt_pkg::cmd_t  pop_cmd;

  astt_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // The queue lets the back end stall on the output while requests still
  // arrive, and lets the front end idle while results drain.
  astt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // The back end owns the label rotation, the generation count and the
  // outstanding and fault flags. It takes the next item whenever its output
  // register is empty or being emptied in the same cycle.
  astt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/core/astt_checker.sv
// ----------------------------------------------------------------------------
// astt_checker
// Port-level checks on the tracker's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module astt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_status,
  input logic [7:0]  out_header,
  input logic [5:0]  out_signal,
  input logic [1:0]  out_frame,
  input logic [15:0] out_ticket,
  input logic [1:0]  out_offset
);

  logic frame_clean;
  logic offset_clean;
  logic fields_clear;

  assign frame_clean  = (out_status == astt_pkg::ST_OK) && (out_header[3:0] == 4'd0) &&
                        (out_signal != 6'd0);
  assign offset_clean = (out_status == astt_pkg::ST_OK) && (out_frame == 2'd0) &&
                        (out_header == 8'd0);
  assign fields_clear = (out_header == 8'd0) && (out_signal == 6'd0) &&
                        (out_frame == 2'd0) && (out_ticket == 16'd0) &&
                        (out_offset == 2'd0);

  // A stalled result beat stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A frame length is issued only with an ok status, a clean header low nibble and a nonzero signal id.
  `ASSERT_SAME(a_frame_ok, out_valid && (out_frame != 2'd0), frame_clean)

  // An accepted response never also carries a header.
  `ASSERT_SAME(a_offset_ok, out_valid && (out_offset != 2'd0), offset_clean)

  // Any failure leaves every other result field at zero.
  `ASSERT_SAME(a_fail_clean, out_valid && (out_status != astt_pkg::ST_OK), fields_clear)

endmodule

bind avdtp_signal_transaction_tracker_unit astt_checker u_astt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_header (out_ch.header_out),
  .out_signal (out_ch.signal_out),
  .out_frame  (out_ch.frame_length),
  .out_ticket (out_ch.ticket_out),
  .out_offset (out_ch.data_offset)
);
